/* hdl/closest_point_on_triangle_defines.svh */
// Assertion macros for the closest point on triangle block.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH
`define CLOSEST_POINT_ON_TRIANGLE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset
`define CPT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpt assertion failed");
// Checked on every edge, reset included
`define CPT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cpt assertion failed");
`else
`define CPT_ASSERT(lbl, prop)
`define CPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* hdl/cpt_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, types and helpers for the closest point on triangle block.
// No dependencies.
package cpt_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int OUT_BITS   = 32;

    // Edge and offset vectors, their products and dot products
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DOT_BITS   = PROD_BITS + 2;
    localparam int EXT_BITS   = DOT_BITS + 2;
    // Magnitudes of dot products and their split for partial products
    localparam int MAG_BITS   = 2 * COORD_BITS + 2;
    localparam int HALF_BITS  = MAG_BITS / 2;
    localparam int PP_BITS    = 2 * HALF_BITS;
    localparam int PMAG_BITS  = 2 * MAG_BITS;
    localparam int WIDE_BITS  = PMAG_BITS + 4;
    localparam int REM_BITS   = WIDE_BITS + 1;
    // Barycentric weights and the blend
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int WT_BITS    = FRAC_BITS + 2;
    localparam int BP_BITS    = COORD_BITS + WT_BITS;
    localparam int SUM_BITS   = BP_BITS + 2;
    localparam int SAT_BITS   = (SUM_BITS > OUT_BITS) ? SUM_BITS : OUT_BITS + 1;

    localparam logic [Q_BITS-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Index 0 is x, 1 is y, 2 is z
    typedef logic [2:0][COORD_BITS-1:0] vec_t;

    typedef struct packed {
        vec_t p0;
        vec_t p1;
        vec_t p2;
    } tri_t;

    // Travels alongside the divider lanes
    typedef struct packed {
        tri_t verts;
        logic t_comp;
    } side_t;

    function automatic logic signed [EXT_BITS-1:0] sext_ext(
        input logic signed [DOT_BITS-1:0] x);
        return {{(EXT_BITS - DOT_BITS){x[DOT_BITS-1]}}, x};
    endfunction

    function automatic logic signed [WIDE_BITS-1:0] sext_wide(
        input logic signed [EXT_BITS-1:0] x);
        return {{(WIDE_BITS - EXT_BITS){x[EXT_BITS-1]}}, x};
    endfunction

endpackage

/* hdl/cpt_dots.sv */
`timescale 1ns / 1ps
// Edge vectors and the five dot products a..e, three register stages.
// Depends on cpt_pkg.
module cpt_dots (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  cpt_pkg::tri_t                          verts,
    input  cpt_pkg::vec_t                          query,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [cpt_pkg::DOT_BITS-1:0]    a,
    output logic signed [cpt_pkg::DOT_BITS-1:0]    b,
    output logic signed [cpt_pkg::DOT_BITS-1:0]    c,
    output logic signed [cpt_pkg::DOT_BITS-1:0]    d,
    output logic signed [cpt_pkg::DOT_BITS-1:0]    e,
    output cpt_pkg::tri_t                          verts_d
);

    localparam int NST = 3;
    localparam int CB  = cpt_pkg::COORD_BITS;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic signed [cpt_pkg::DIFF_BITS-1:0] e0_next [3];
    logic signed [cpt_pkg::DIFF_BITS-1:0] e1_next [3];
    logic signed [cpt_pkg::DIFF_BITS-1:0] w_next  [3];
    logic signed [cpt_pkg::DIFF_BITS-1:0] e0_reg  [3];
    logic signed [cpt_pkg::DIFF_BITS-1:0] e1_reg  [3];
    logic signed [cpt_pkg::DIFF_BITS-1:0] w_reg   [3];
    logic signed [cpt_pkg::PROD_BITS-1:0] pa_reg  [3];
    logic signed [cpt_pkg::PROD_BITS-1:0] pb_reg  [3];
    logic signed [cpt_pkg::PROD_BITS-1:0] pc_reg  [3];
    logic signed [cpt_pkg::PROD_BITS-1:0] pd_reg  [3];
    logic signed [cpt_pkg::PROD_BITS-1:0] pe_reg  [3];
    logic signed [cpt_pkg::DOT_BITS-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    cpt_pkg::tri_t                        verts_reg [NST];

    // Stage ready chain: a stage loads when empty or when its successor moves
    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Edge vectors and offset from query to first vertex
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e0_next[k] = $signed({verts.p1[k][CB-1], verts.p1[k]})
                       - $signed({verts.p0[k][CB-1], verts.p0[k]});
            e1_next[k] = $signed({verts.p2[k][CB-1], verts.p2[k]})
                       - $signed({verts.p0[k][CB-1], verts.p0[k]});
            w_next[k]  = $signed({verts.p0[k][CB-1], verts.p0[k]})
                       - $signed({query[k][CB-1], query[k]});
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int k = 0; k < 3; k++)
            begin
                e0_reg[k] <= e0_next[k];
                e1_reg[k] <= e1_next[k];
                w_reg[k]  <= w_next[k];
            end
            verts_reg[0] <= verts;
        end
        // per-axis products
        if (rdy[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                pa_reg[k] <= e0_reg[k] * e0_reg[k];
                pb_reg[k] <= e0_reg[k] * e1_reg[k];
                pc_reg[k] <= e1_reg[k] * e1_reg[k];
                pd_reg[k] <= e0_reg[k] * w_reg[k];
                pe_reg[k] <= e1_reg[k] * w_reg[k];
            end
            verts_reg[1] <= verts_reg[0];
        end
        // three-term sums
        if (rdy[2])
        begin
            a_reg <= cpt_pkg::DOT_BITS'(pa_reg[0]) + cpt_pkg::DOT_BITS'(pa_reg[1])
                   + cpt_pkg::DOT_BITS'(pa_reg[2]);
            b_reg <= cpt_pkg::DOT_BITS'(pb_reg[0]) + cpt_pkg::DOT_BITS'(pb_reg[1])
                   + cpt_pkg::DOT_BITS'(pb_reg[2]);
            c_reg <= cpt_pkg::DOT_BITS'(pc_reg[0]) + cpt_pkg::DOT_BITS'(pc_reg[1])
                   + cpt_pkg::DOT_BITS'(pc_reg[2]);
            d_reg <= cpt_pkg::DOT_BITS'(pd_reg[0]) + cpt_pkg::DOT_BITS'(pd_reg[1])
                   + cpt_pkg::DOT_BITS'(pd_reg[2]);
            e_reg <= cpt_pkg::DOT_BITS'(pe_reg[0]) + cpt_pkg::DOT_BITS'(pe_reg[1])
                   + cpt_pkg::DOT_BITS'(pe_reg[2]);
            verts_reg[2] <= verts_reg[1];
        end
    end

    assign a       = a_reg;
    assign b       = b_reg;
    assign c       = c_reg;
    assign d       = d_reg;
    assign e       = e_reg;
    assign verts_d = verts_reg[NST-1];

endmodule

/* hdl/cpt_cross.sv */
`timescale 1ns / 1ps
// Wide cross terms det, sn, tn from split partial products, then region
// selection of numerator and denominator per parameter. Depends on cpt_pkg.
module cpt_cross (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [cpt_pkg::DOT_BITS-1:0]     a,
    input  logic signed [cpt_pkg::DOT_BITS-1:0]     b,
    input  logic signed [cpt_pkg::DOT_BITS-1:0]     c,
    input  logic signed [cpt_pkg::DOT_BITS-1:0]     d,
    input  logic signed [cpt_pkg::DOT_BITS-1:0]     e,
    input  cpt_pkg::tri_t                           verts,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cpt_pkg::WIDE_BITS-1:0]    num_s,
    output logic signed [cpt_pkg::WIDE_BITS-1:0]    den_s,
    output logic signed [cpt_pkg::WIDE_BITS-1:0]    num_t,
    output logic signed [cpt_pkg::WIDE_BITS-1:0]    den_t,
    output cpt_pkg::side_t                          side
);

    localparam int NST   = 5;
    localparam int NOPS  = 5;
    localparam int NPROD = 6;
    localparam int W     = cpt_pkg::WIDE_BITS;
    localparam int HB    = cpt_pkg::HALF_BITS;
    localparam int MB    = cpt_pkg::MAG_BITS;
    localparam int XB    = cpt_pkg::EXT_BITS;
    // operand order a, b, c, d, e; product order ac, bb, be, cd, bd, ae
    localparam int LHS [NPROD] = '{0, 1, 1, 2, 1, 0};
    localparam int RHS [NPROD] = '{2, 1, 4, 3, 3, 4};
    localparam logic signed [W-1:0] UNIT_DEN = W'(1);

    typedef struct packed {
        logic signed [XB-1:0] a;
        logic signed [XB-1:0] c;
        logic signed [XB-1:0] nd;
        logic signed [XB-1:0] ne;
        logic signed [XB-1:0] n2;
        logic signed [XB-1:0] den2;
        logic                 d_neg;
        logic                 n2_pos;
        logic                 ad_gt;
    } aux_t;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic signed [cpt_pkg::DOT_BITS-1:0] op     [NOPS];
    logic signed [cpt_pkg::DOT_BITS-1:0] abs_v  [NOPS];
    logic [MB-1:0]                       mag_reg [NOPS];
    logic [NOPS-1:0]                     sgn_reg;
    aux_t                                aux_next;
    aux_t                                aux_reg [NST-1];
    cpt_pkg::tri_t                       verts_reg [NST];

    logic [cpt_pkg::PP_BITS-1:0]         pp_reg [NPROD][4];
    logic [NPROD-1:0]                    psgn_reg;
    logic [cpt_pkg::PMAG_BITS-1:0]       pmag   [NPROD];
    logic signed [W-1:0]                 pwide  [NPROD];
    logic signed [W-1:0]                 prod_reg [NPROD];
    logic signed [W-1:0]                 det_reg, sn_reg, tn_reg;

    logic signed [W:0]                   sum_st, det_x;
    logic                                in_tri, snn, tnn;
    aux_t                                ax;
    logic signed [W-1:0]                 ns, ds, nt, dt;
    logic                                tc;
    logic signed [W-1:0]                 ns_reg, ds_reg, nt_reg, dt_reg;
    logic                                tc_reg;
    logic signed [XB-1:0]                ad_sum, be_sum;

    // Stage ready chain
    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // Magnitudes, signs and the narrow region terms
    always_comb
    begin
        op[0] = a;
        op[1] = b;
        op[2] = c;
        op[3] = d;
        op[4] = e;
        for (int i = 0; i < NOPS; i++)
        begin
            abs_v[i] = op[i][cpt_pkg::DOT_BITS-1] ? -op[i] : op[i];
        end
        ad_sum          = cpt_pkg::sext_ext(a) + cpt_pkg::sext_ext(d);
        be_sum          = cpt_pkg::sext_ext(b) + cpt_pkg::sext_ext(e);
        aux_next.a      = cpt_pkg::sext_ext(a);
        aux_next.c      = cpt_pkg::sext_ext(c);
        aux_next.nd     = -cpt_pkg::sext_ext(d);
        aux_next.ne     = -cpt_pkg::sext_ext(e);
        aux_next.n2     = (cpt_pkg::sext_ext(c) - cpt_pkg::sext_ext(d))
                        + (cpt_pkg::sext_ext(e) - cpt_pkg::sext_ext(b));
        aux_next.den2   = cpt_pkg::sext_ext(a) - (cpt_pkg::sext_ext(b) <<< 1)
                        + cpt_pkg::sext_ext(c);
        aux_next.d_neg  = d[cpt_pkg::DOT_BITS-1];
        aux_next.ad_gt  = ad_sum > be_sum;
        aux_next.n2_pos = !aux_next.n2[XB-1] && (aux_next.n2 != '0);
    end

    // Partial products are recombined one stage after they are formed
    always_comb
    begin
        for (int j = 0; j < NPROD; j++)
        begin
            pmag[j] = cpt_pkg::PMAG_BITS'(pp_reg[j][0])
                    + (cpt_pkg::PMAG_BITS'(pp_reg[j][1]) << HB)
                    + (cpt_pkg::PMAG_BITS'(pp_reg[j][2]) << HB)
                    + (cpt_pkg::PMAG_BITS'(pp_reg[j][3]) << (2 * HB));
            pwide[j] = $signed({{(W - cpt_pkg::PMAG_BITS){1'b0}}, pmag[j]});
        end
    end

    // Region selection of the two divider lanes
    always_comb
    begin
        sum_st = $signed({sn_reg[W-1], sn_reg}) + $signed({tn_reg[W-1], tn_reg});
        det_x  = $signed({det_reg[W-1], det_reg});
        in_tri = sum_st < det_x;
        snn    = sn_reg[W-1];
        tnn    = tn_reg[W-1];
        ax     = aux_reg[NST-2];
        ns     = '0;
        ds     = UNIT_DEN;
        nt     = '0;
        dt     = UNIT_DEN;
        tc     = 1'b0;
        if (in_tri)
        begin
            if (snn && !(tnn && ax.d_neg))
            begin
                // edge along second vertex direction
                nt = cpt_pkg::sext_wide(ax.ne);
                dt = cpt_pkg::sext_wide(ax.c);
            end
            else if (snn || tnn)
            begin
                // edge along first vertex direction
                ns = cpt_pkg::sext_wide(ax.nd);
                ds = cpt_pkg::sext_wide(ax.a);
            end
            else
            begin
                // interior
                ns = sn_reg;
                ds = det_reg;
                nt = tn_reg;
                dt = det_reg;
            end
        end
        else
        begin
            if (snn && !ax.n2_pos)
            begin
                nt = cpt_pkg::sext_wide(ax.ne);
                dt = cpt_pkg::sext_wide(ax.c);
            end
            else if (!snn && tnn && !ax.ad_gt)
            begin
                ns = cpt_pkg::sext_wide(ax.nd);
                ds = cpt_pkg::sext_wide(ax.a);
            end
            else
            begin
                // edge opposite the first vertex, t follows as 1 - s
                ns = cpt_pkg::sext_wide(ax.n2);
                ds = cpt_pkg::sext_wide(ax.den2);
                tc = 1'b1;
            end
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            for (int i = 0; i < NOPS; i++)
            begin
                mag_reg[i] <= abs_v[i][MB-1:0];
                sgn_reg[i] <= op[i][cpt_pkg::DOT_BITS-1];
            end
            aux_reg[0]   <= aux_next;
            verts_reg[0] <= verts;
        end
        // split 17 x 17 partial products
        if (rdy[1])
        begin
            for (int j = 0; j < NPROD; j++)
            begin
                pp_reg[j][0] <= mag_reg[LHS[j]][HB-1:0] * mag_reg[RHS[j]][HB-1:0];
                pp_reg[j][1] <= mag_reg[LHS[j]][HB-1:0] * mag_reg[RHS[j]][MB-1:HB];
                pp_reg[j][2] <= mag_reg[LHS[j]][MB-1:HB] * mag_reg[RHS[j]][HB-1:0];
                pp_reg[j][3] <= mag_reg[LHS[j]][MB-1:HB] * mag_reg[RHS[j]][MB-1:HB];
                psgn_reg[j]  <= sgn_reg[LHS[j]] ^ sgn_reg[RHS[j]];
            end
            aux_reg[1]   <= aux_reg[0];
            verts_reg[1] <= verts_reg[0];
        end
        // signed wide products
        if (rdy[2])
        begin
            for (int j = 0; j < NPROD; j++)
            begin
                prod_reg[j] <= psgn_reg[j] ? -pwide[j] : pwide[j];
            end
            aux_reg[2]   <= aux_reg[1];
            verts_reg[2] <= verts_reg[1];
        end
        // det, sn, tn
        if (rdy[3])
        begin
            det_reg      <= prod_reg[0] - prod_reg[1];
            sn_reg       <= prod_reg[2] - prod_reg[3];
            tn_reg       <= prod_reg[4] - prod_reg[5];
            aux_reg[3]   <= aux_reg[2];
            verts_reg[3] <= verts_reg[2];
        end
        if (rdy[4])
        begin
            ns_reg       <= ns;
            ds_reg       <= ds;
            nt_reg       <= nt;
            dt_reg       <= dt;
            tc_reg       <= tc;
            verts_reg[4] <= verts_reg[3];
        end
    end

    assign num_s       = ns_reg;
    assign den_s       = ds_reg;
    assign num_t       = nt_reg;
    assign den_t       = dt_reg;
    assign side.verts  = verts_reg[NST-1];
    assign side.t_comp = tc_reg;

endmodule

/* hdl/cpt_div.sv */
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider: clamped ratio num/den in [0,1] floored to
// FRAC_BITS fraction bits, one quotient bit per stage after entry. Depends on cpt_pkg.
module cpt_div (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [cpt_pkg::WIDE_BITS-1:0]    num_s,
    input  logic signed [cpt_pkg::WIDE_BITS-1:0]    den_s,
    input  logic signed [cpt_pkg::WIDE_BITS-1:0]    num_t,
    input  logic signed [cpt_pkg::WIDE_BITS-1:0]    den_t,
    input  cpt_pkg::side_t                          side,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [cpt_pkg::Q_BITS-1:0]              q_s,
    output logic [cpt_pkg::Q_BITS-1:0]              q_t,
    output logic                                    degen,
    output cpt_pkg::side_t                          side_d
);

    localparam int FB  = cpt_pkg::FRAC_BITS;
    localparam int NST = FB + 1;
    localparam int W   = cpt_pkg::WIDE_BITS;
    localparam int RB  = cpt_pkg::REM_BITS;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic signed [W-1:0] num_in [2];
    logic signed [W-1:0] den_in [2];

    logic [RB-1:0]  rem_reg  [2][NST];
    logic [RB-1:0]  dv_reg   [2][NST];
    logic [FB-1:0]  q_reg    [2][NST];
    logic           one_reg  [2][NST];
    logic           zero_reg [2][NST];
    logic           deg_reg  [2][NST];
    cpt_pkg::side_t side_reg [NST];

    logic [RB-1:0]  rem_next [2][NST];
    logic [FB-1:0]  q_next   [2][NST];
    logic [RB-1:0]  shl      [2][NST];
    logic           ge       [2][NST];
    logic [cpt_pkg::Q_BITS-1:0] q_out [2];

    // Stage ready chain
    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // One shift-compare-subtract per stage after the entry stage
    always_comb
    begin
        num_in[0] = num_s;
        num_in[1] = num_t;
        den_in[0] = den_s;
        den_in[1] = den_t;
        for (int l = 0; l < 2; l++)
        begin
            shl[l][0]      = '0;
            ge[l][0]       = 1'b0;
            rem_next[l][0] = {1'b0, num_in[l]};
            q_next[l][0]   = '0;
            for (int k = 1; k < NST; k++)
            begin
                shl[l][k]      = {rem_reg[l][k-1][RB-2:0], 1'b0};
                ge[l][k]       = shl[l][k] >= dv_reg[l][k-1];
                rem_next[l][k] = ge[l][k] ? shl[l][k] - dv_reg[l][k-1] : shl[l][k];
                q_next[l][k]   = {q_reg[l][k-1][FB-2:0], ge[l][k]};
            end
        end
    end

    // Stage registers
    always_ff @(posedge clk)
    begin
        // entry: special cases of the clamp
        if (rdy[0])
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l][0]  <= rem_next[l][0];
                q_reg[l][0]    <= q_next[l][0];
                dv_reg[l][0]   <= {1'b0, den_in[l]};
                deg_reg[l][0]  <= den_in[l][W-1] || (den_in[l] == '0);
                zero_reg[l][0] <= num_in[l][W-1] || (num_in[l] == '0);
                one_reg[l][0]  <= num_in[l] >= den_in[l];
            end
            side_reg[0] <= side;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (rdy[k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rem_reg[l][k]  <= rem_next[l][k];
                    q_reg[l][k]    <= q_next[l][k];
                    dv_reg[l][k]   <= dv_reg[l][k-1];
                    deg_reg[l][k]  <= deg_reg[l][k-1];
                    zero_reg[l][k] <= zero_reg[l][k-1];
                    one_reg[l][k]  <= one_reg[l][k-1];
                end
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Clamp: divisor <= 0 or non-positive ratio gives 0, ratio at or above 1 gives 1
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (deg_reg[l][NST-1] || zero_reg[l][NST-1])
            begin
                q_out[l] = '0;
            end
            else if (one_reg[l][NST-1])
            begin
                q_out[l] = cpt_pkg::Q_ONE;
            end
            else
            begin
                q_out[l] = {1'b0, q_reg[l][NST-1]};
            end
        end
    end

    assign q_s    = q_out[0];
    assign q_t    = q_out[1];
    assign degen  = deg_reg[0][NST-1] || deg_reg[1][NST-1];
    assign side_d = side_reg[NST-1];

endmodule

/* hdl/closest_point_on_triangle.sv */
`timescale 1ns / 1ps
// Top level: closest point on a triangle to a query point, Q16.16 result.
// Depends on cpt_pkg, cpt_dots, cpt_cross, cpt_div and the defines header.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  input   | in        | in_valid / in_ready    | v0..v2 and query, x y z each
//  result  | out       | out_valid / out_ready  | near_x, near_y, near_z, degenerate
//
// One transaction per cycle sustained while results are accepted; 3 dot-product
// stages, 5 cross-term and region stages, 17 divider stages (entry, then one
// quotient bit each) and 3 blend stages. Reset clears only the stage valid bits.
// Each stage holds while its successor is stalled; empty stages keep filling, so
// a stalled result blocks input only once every stage is occupied.
`include "closest_point_on_triangle_defines.svh"

module closest_point_on_triangle (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v0_x,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v0_y,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v0_z,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v1_x,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v1_y,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v1_z,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v2_x,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v2_y,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     v2_z,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     query_x,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     query_y,
    input  logic signed [cpt_pkg::COORD_BITS-1:0]     query_z,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic signed [cpt_pkg::OUT_BITS-1:0]       near_x,
    output logic signed [cpt_pkg::OUT_BITS-1:0]       near_y,
    output logic signed [cpt_pkg::OUT_BITS-1:0]       near_z,
    output logic                                      degenerate
);

    localparam int NST = 3;
    localparam int WB  = cpt_pkg::WT_BITS;
    localparam int SB  = cpt_pkg::SAT_BITS;
    localparam int OB  = cpt_pkg::OUT_BITS;
    localparam logic signed [WB-1:0] ONE_W = WB'(cpt_pkg::Q_ONE);
    localparam logic [OB-1:0] POS_MAX = {1'b0, {(OB - 1){1'b1}}};
    localparam logic [OB-1:0] NEG_MIN = {1'b1, {(OB - 1){1'b0}}};

    cpt_pkg::tri_t verts;
    cpt_pkg::vec_t query;

    logic                                  dots_valid, dots_ready;
    logic signed [cpt_pkg::DOT_BITS-1:0]   a, b, c, d, e;
    cpt_pkg::tri_t                         verts_dots;

    logic                                  cross_valid, cross_ready;
    logic signed [cpt_pkg::WIDE_BITS-1:0]  num_s, den_s, num_t, den_t;
    cpt_pkg::side_t                        side_cross;

    logic                                  div_valid, div_ready;
    logic [cpt_pkg::Q_BITS-1:0]            q_s, q_t;
    logic                                  div_degen;
    cpt_pkg::side_t                        side_div;

    logic [NST-1:0]                        bvld_reg;
    logic [NST:0]                          brdy;
    logic signed [WB-1:0]                  s_w, t_w, u_w;
    logic signed [WB-1:0]                  s_reg, t_reg, u_reg;
    logic                                  deg_reg [NST];
    cpt_pkg::tri_t                         verts_reg;
    logic signed [cpt_pkg::BP_BITS-1:0]    bp_reg [3][3];
    logic signed [SB-1:0]                  sum    [3];
    logic [SB-OB:0]                        hi     [3];
    logic [OB-1:0]                         sat    [3];
    logic [OB-1:0]                         near_reg [3];

    assign verts.p0 = {v0_z, v0_y, v0_x};
    assign verts.p1 = {v1_z, v1_y, v1_x};
    assign verts.p2 = {v2_z, v2_y, v2_x};
    assign query    = {query_z, query_y, query_x};

    cpt_dots u_dots (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .verts     (verts),
        .query     (query),
        .out_valid (dots_valid),
        .out_ready (dots_ready),
        .a         (a),
        .b         (b),
        .c         (c),
        .d         (d),
        .e         (e),
        .verts_d   (verts_dots)
    );

    cpt_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dots_valid),
        .in_ready  (dots_ready),
        .a         (a),
        .b         (b),
        .c         (c),
        .d         (d),
        .e         (e),
        .verts     (verts_dots),
        .out_valid (cross_valid),
        .out_ready (cross_ready),
        .num_s     (num_s),
        .den_s     (den_s),
        .num_t     (num_t),
        .den_t     (den_t),
        .side      (side_cross)
    );

    cpt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cross_valid),
        .in_ready  (cross_ready),
        .num_s     (num_s),
        .den_s     (den_s),
        .num_t     (num_t),
        .den_t     (den_t),
        .side      (side_cross),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .q_s       (q_s),
        .q_t       (q_t),
        .degen     (div_degen),
        .side_d    (side_div)
    );

    // Blend stage ready chain
    always_comb
    begin
        brdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            brdy[k] = !bvld_reg[k] || brdy[k+1];
        end
    end

    assign div_ready = brdy[0];
    assign out_valid = bvld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvld_reg <= '0;
        end
        else
        begin
            if (brdy[0])
            begin
                bvld_reg[0] <= div_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (brdy[k])
                begin
                    bvld_reg[k] <= bvld_reg[k-1];
                end
            end
        end
    end

    // Barycentric weights
    always_comb
    begin
        s_w = $signed({1'b0, q_s});
        t_w = side_div.t_comp ? ONE_W - s_w : $signed({1'b0, q_t});
        u_w = ONE_W - s_w - t_w;
    end

    // Weighted sum with saturation to the output width
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum[k] = SB'(bp_reg[k][0]) + SB'(bp_reg[k][1]) + SB'(bp_reg[k][2]);
            hi[k]  = sum[k][SB-1:OB-1];
            if ((&hi[k]) || !(|hi[k]))
            begin
                sat[k] = sum[k][OB-1:0];
            end
            else
            begin
                sat[k] = sum[k][SB-1] ? NEG_MIN : POS_MAX;
            end
        end
    end

    // Blend registers
    always_ff @(posedge clk)
    begin
        if (brdy[0])
        begin
            s_reg      <= s_w;
            t_reg      <= t_w;
            u_reg      <= u_w;
            deg_reg[0] <= div_degen;
            verts_reg  <= side_div.verts;
        end
        // one product per vertex and axis
        if (brdy[1])
        begin
            for (int k = 0; k < 3; k++)
            begin
                bp_reg[k][0] <= $signed(verts_reg.p0[k]) * u_reg;
                bp_reg[k][1] <= $signed(verts_reg.p1[k]) * s_reg;
                bp_reg[k][2] <= $signed(verts_reg.p2[k]) * t_reg;
            end
            deg_reg[1] <= deg_reg[0];
        end
        if (brdy[2])
        begin
            for (int k = 0; k < 3; k++)
            begin
                near_reg[k] <= sat[k];
            end
            deg_reg[2] <= deg_reg[1];
        end
    end

    assign near_x     = near_reg[0];
    assign near_y     = near_reg[1];
    assign near_z     = near_reg[2];
    assign degenerate = deg_reg[NST-1];

    // Input back-pressure can only come from a held result
    `CPT_ASSERT_ALWAYS(a_stall_src, !in_ready |-> (out_valid && !out_ready))
    // Clamped parameters never exceed one
    `CPT_ASSERT(a_q_range, div_valid |-> (q_s <= cpt_pkg::Q_ONE && q_t <= cpt_pkg::Q_ONE))
    // Weight of the first vertex never goes negative
    `CPT_ASSERT(a_u_nonneg, bvld_reg[0] |-> !u_reg[cpt_pkg::WT_BITS-1])

endmodule

/* test/tb_closest_point_on_triangle.sv */
`timescale 1ns / 1ps
// Testbench for closest_point_on_triangle: directed corner cases then random triangles,
// each result checked against an exact integer prediction. Depends on cpt_pkg and the RTL.
module tb_closest_point_on_triangle;

    localparam int LATENCY = 28;
    localparam int N_RANDOM = 1700;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
    } near_t;

    typedef struct {
        logic signed [15:0] c[12];
        bit                 typed;   // expected value written in the row
        near_t              want;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [15:0] v0_x, v0_y, v0_z, v1_x, v1_y, v1_z;
    logic signed [15:0] v2_x, v2_y, v2_z, query_x, query_y, query_z;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] near_x, near_y, near_z;
    logic degenerate;

    near_t expected_points[$];
    int    n_fail;
    int    n_sent;
    int    n_got;
    int    n_degen;
    bit    stall_enable;

    closest_point_on_triangle dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Clamped num/den floored to 16 fraction bits; den <= 0 flags degenerate
    function automatic longint clamp_ratio(input logic signed [127:0] num,
                                           input logic signed [127:0] den,
                                           inout bit degen);
        logic signed [127:0] q;
        if (den <= 0)
        begin
            degen = 1'b1;
            return 0;
        end
        if (num <= 0)
            return 0;
        if (num >= den)
            return 64'sd1 << cpt_pkg::FRAC_BITS;
        q = (num <<< cpt_pkg::FRAC_BITS) / den;
        return longint'(q);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
        if (v > 128'sh7fffffff)
            return 32'sh7fffffff;
        if (v < -128'sh80000000)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // Region-based closest point, exact on wide integers
    function automatic near_t closest_point(input logic signed [15:0] c[12]);
        logic signed [127:0] p0[3], p1[3], p2[3], e0[3], e1[3], w[3];
        logic signed [127:0] a, b, cc, d, e, det, sn, tn, s, t, one;
        bit degen;
        near_t r;
        a = 0; b = 0; cc = 0; d = 0; e = 0; degen = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            p0[k] = c[k]; p1[k] = c[3+k]; p2[k] = c[6+k];
            e0[k] = p1[k] - p0[k];
            e1[k] = p2[k] - p0[k];
            w[k] = p0[k] - c[9+k];
            a += e0[k] * e0[k]; b += e0[k] * e1[k]; cc += e1[k] * e1[k];
            d += e0[k] * w[k]; e += e1[k] * w[k];
        end
        one = 128'sd1 << cpt_pkg::FRAC_BITS;
        det = a * cc - b * b;
        sn = b * e - cc * d;
        tn = b * d - a * e;
        if (sn + tn < det)
        begin
            if (sn < 0)
            begin
                if (tn < 0 && d < 0)
                begin
                    s = clamp_ratio(-d, a, degen); t = 0;
                end
                else
                begin
                    s = 0; t = clamp_ratio(-e, cc, degen);
                end
            end
            else if (tn < 0)
            begin
                s = clamp_ratio(-d, a, degen); t = 0;
            end
            else
            begin
                s = clamp_ratio(sn, det, degen);
                t = clamp_ratio(tn, det, degen);
            end
        end
        else if (sn < 0 && !(cc + e > b + d))
        begin
            t = clamp_ratio(-e, cc, degen); s = 0;
        end
        else if (sn >= 0 && tn < 0 && !(a + d > b + e))
        begin
            s = clamp_ratio(-d, a, degen); t = 0;
        end
        else
        begin
            s = clamp_ratio(cc + e - b - d, a - 2 * b + cc, degen); t = one - s;
        end
        r.x = sat32(p0[0] * (one - s - t) + p1[0] * s + p2[0] * t);
        r.y = sat32(p0[1] * (one - s - t) + p1[1] * s + p2[1] * t);
        r.z = sat32(p0[2] * (one - s - t) + p1[2] * s + p2[2] * t);
        r.degen = degen;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    // Valid stays high across back-to-back transactions; it drops only for a gap
    task automatic send(input logic signed [15:0] c[12], input near_t want);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (stall_enable && gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z} <= {c[0], c[1], c[2], c[3], c[4], c[5]};
        {v2_x, v2_y, v2_z} <= {c[6], c[7], c[8]};
        {query_x, query_y, query_z} <= {c[9], c[10], c[11]};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_points.insert(expected_points.size(), want);
        n_sent++;
    endtask

    // Result side: random back-pressure and compare
    initial
    begin
        near_t want;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready && rst_n)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result transaction");
                    n_fail++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    n_got++;
                    if (want.degen)
                        n_degen++;
                    if (near_x !== want.x)
                    begin
                        $error("near_x expected %0d got %0d", want.x, near_x); n_fail++;
                    end
                    if (near_y !== want.y)
                    begin
                        $error("near_y expected %0d got %0d", want.y, near_y); n_fail++;
                    end
                    if (near_z !== want.z)
                    begin
                        $error("near_z expected %0d got %0d", want.z, near_z); n_fail++;
                    end
                    if (degenerate !== want.degen)
                    begin
                        $error("degenerate expected %0d got %0d", want.degen, degenerate);
                        n_fail++;
                    end
                end
            end
            if (!stall_enable)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 49) == 0)
                out_ready <= 1'b0;
            else if (!out_ready)
                out_ready <= ($urandom_range(0, 5) == 0);
            else
                out_ready <= ($urandom_range(0, 7) != 0);
        end
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        row_t rows[$];
        row_t r;
        logic signed [15:0] c[12];
        near_t want;
        int tail;
        n_fail = 0; n_sent = 0; n_got = 0; n_degen = 0;
        stall_enable = 1'b0;
        rst_n = 1'b0; in_valid = 1'b0;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z} = '0;
        {v2_x, v2_y, v2_z, query_x, query_y, query_z} = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fully collapsed triangle: degenerate, point is the vertex
        r.c = '{5, -3, 7, 5, -3, 7, 5, -3, 7, 100, 100, 100};
        r.typed = 1; r.want = '{5 << 16, -3 << 16, 7 << 16, 1'b1};
        rows.insert(rows.size(), r);
        // All at origin
        r.c = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        r.typed = 1; r.want = '{0, 0, 0, 1'b1}; rows.insert(rows.size(), r);
        // Query on vertex 0
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, 0, 0, 0};
        r.typed = 1; r.want = '{0, 0, 0, 1'b0}; rows.insert(rows.size(), r);
        // Query inside, above the plane; weights are truncated fractions
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, 2, 3, 9};
        r.typed = 0; rows.insert(rows.size(), r);
        // Beyond vertex 1, vertex 2
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, 50, -5, 0};
        r.typed = 1; r.want = '{10 << 16, 0, 0, 1'b0}; rows.insert(rows.size(), r);
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, -5, 50, 0};
        r.typed = 1; r.want = '{0, 10 << 16, 0, 1'b0}; rows.insert(rows.size(), r);
        // Edge regions, hypotenuse, outside vertex 0
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, 4, -7, 1}; r.typed = 0;
        rows.insert(rows.size(), r);
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, -7, 4, 1}; r.typed = 0;
        rows.insert(rows.size(), r);
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, 9, 8, -2}; r.typed = 0;
        rows.insert(rows.size(), r);
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, -3, -4, 0}; r.typed = 0;
        rows.insert(rows.size(), r);
        r.c = '{0, 0, 0, 3, 0, 0, 0, 7, 0, 1, 1, 0}; r.typed = 0;
        rows.insert(rows.size(), r);
        // Beyond vertex 1 with edge opposite vertex 0
        r.c = '{0, 0, 0, 10, 0, 0, 0, 10, 0, 20, 1, 0}; r.typed = 0;
        rows.insert(rows.size(), r);
        // Degenerate edges: V1 = V0, V2 = V0, V1 = V2
        r.c = '{1, 2, 3, 1, 2, 3, 9, -4, 6, 20, 20, 20}; r.typed = 0;
        rows.insert(rows.size(), r);
        r.c = '{1, 2, 3, 9, -4, 6, 1, 2, 3, -20, 7, 0}; r.typed = 0;
        rows.insert(rows.size(), r);
        r.c = '{1, 2, 3, 9, -4, 6, 9, -4, 6, 30, -9, 8}; r.typed = 0;
        rows.insert(rows.size(), r);
        // Collinear, non-coincident
        r.c = '{0, 0, 0, 5, 5, 5, 10, 10, 10, 3, -1, 2}; r.typed = 0;
        rows.insert(rows.size(), r);
        // Field extremes
        r.c = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768,
                32767, -32768, 32767};
        r.typed = 0; rows.insert(rows.size(), r);
        r.c = '{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767, -32768, -32768, -32768};
        r.typed = 0; rows.insert(rows.size(), r);
        r.c = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1}; r.typed = 0;
        rows.insert(rows.size(), r);

        foreach (rows[i])
        begin
            want = rows[i].typed ? rows[i].want : closest_point(rows[i].c);
            if (rows[i].typed && want != closest_point(rows[i].c))
            begin
                $error("directed row %0d prediction disagrees with table", i);
                n_fail++;
            end
            send(rows[i].c, want);
        end

        stall_enable = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Halfway: let the pipeline drain completely before going on
            if (i == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                while (expected_points.size() != 0)
                    @(posedge clk);
            end
            // Bursts with no idling on either side
            stall_enable = !((i / 200) % 3 == 2);
            for (int k = 0; k < 12; k++)
                c[k] = rand_coord();
            // Sometimes collapse vertices to hit the zero-divisor cases
            case ($urandom_range(0, 11))
                0: c[3:5] = c[0:2];
                1: c[6:8] = c[0:2];
                2: c[6:8] = c[3:5];
                default: ;
            endcase
            send(c, closest_point(c));
        end

        in_valid <= 1'b0;
        stall_enable = 1'b1;
        while (expected_points.size() != 0)
            @(posedge clk);
        tail = 0;
        while (tail < 4 * LATENCY)
        begin
            @(posedge clk);
            tail++;
        end
        $display("Sent %0d triangle queries, %0d results checked, %0d degenerate.",
                 n_sent, n_got, n_degen);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
